FILE: rtl/pab_pkg.sv
// ----------------------------------------------------------------------------
// Polygon area and bounds package
// Shared widths, payload structs and inter-stage records for the polygon
// area and bounding box pipeline.
// ----------------------------------------------------------------------------
package pab_pkg;

    localparam int COORD_W      = 16;
    localparam int MAX_VERTICES = 1024;
    localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);
    localparam int AREA_W       = 43;
    localparam int PAIR_W       = COORD_W + 1;
    localparam int TERM_W       = 2 * PAIR_W;
    localparam int ACC_RAW_W    = TERM_W + COUNT_W;
    localparam int ACC_W        = (ACC_RAW_W > 64) ? 64 :
                                  ((ACC_RAW_W < AREA_W + 1) ? AREA_W + 1 : ACC_RAW_W);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PAIR_W-1:0]  pair_t;
    typedef logic signed [TERM_W-1:0]  term_t;
    typedef logic [ACC_W-1:0]          acc_t;
    typedef logic [COUNT_W-1:0]        count_t;

    localparam acc_t   AREA_CAP  = acc_t'(1) << (AREA_W - 1);
    localparam count_t COUNT_MAX = count_t'(MAX_VERTICES);

    typedef struct packed {
        coord_t vx;
        coord_t vy;
        logic   is_last;
    } pab_in_t;

    typedef struct packed {
        logic [AREA_W-1:0] twice_area;
        coord_t            min_x;
        coord_t            min_y;
        coord_t            max_x;
        coord_t            max_y;
        count_t            vertex_total;
        logic              too_many;
    } pab_out_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t max_x;
        coord_t max_y;
        count_t total;
        logic   ovf;
        logic   last;
    } pab_box_t;

    typedef struct packed {
        pair_t    edge_s;
        pair_t    edge_d;
        pair_t    close_s;
        pair_t    close_d;
        logic     edge_en;
        pab_box_t box;
    } pab_track_t;

    typedef struct packed {
        term_t    edge_prod;
        term_t    close_prod;
        pab_box_t box;
    } pab_prod_t;

    typedef struct packed {
        acc_t     partial;
        term_t    close_prod;
        pab_box_t box;
    } pab_part_t;

endpackage

FILE: rtl/pab_track.sv
// ----------------------------------------------------------------------------
// Polygon vertex tracker
// Holds the first and previous vertex, the bounding box and the vertex
// count, and forms the sum and difference operands of each shoelace term.
// ----------------------------------------------------------------------------
module pab_track (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_stall,
    input  pab_pkg::pab_in_t    up_data,
    output logic                dn_valid,
    input  logic                dn_stall,
    output pab_pkg::pab_track_t dn_data
);
    import pab_pkg::*;

    coord_t     first_x_reg, first_x_next, first_y_reg, first_y_next;
    coord_t     prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    coord_t     min_x_reg, min_x_next, min_y_reg, min_y_next;
    coord_t     max_x_reg, max_x_next, max_y_reg, max_y_next;
    count_t     seen_reg, seen_next;
    logic       ovf_reg, ovf_next;
    logic       valid_reg;
    pab_track_t data_reg, data_next;
    logic       take, is_first, full_hit;

    assign up_stall = valid_reg && dn_stall;
    assign take     = up_valid && !up_stall;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        is_first     = (seen_reg == '0);
        full_hit     = !is_first && (seen_reg == COUNT_MAX);
        first_x_next = is_first ? up_data.vx : first_x_reg;
        first_y_next = is_first ? up_data.vy : first_y_reg;
        prev_x_next  = full_hit ? prev_x_reg : up_data.vx;
        prev_y_next  = full_hit ? prev_y_reg : up_data.vy;
        min_x_next   = (is_first || up_data.vx < min_x_reg) ? up_data.vx : min_x_reg;
        min_y_next   = (is_first || up_data.vy < min_y_reg) ? up_data.vy : min_y_reg;
        max_x_next   = (is_first || up_data.vx > max_x_reg) ? up_data.vx : max_x_reg;
        max_y_next   = (is_first || up_data.vy > max_y_reg) ? up_data.vy : max_y_reg;
        seen_next    = full_hit ? seen_reg : seen_reg + 1'b1;
        ovf_next     = ovf_reg || full_hit;

        data_next.edge_s    = pair_t'(prev_x_reg) + pair_t'(up_data.vx);
        data_next.edge_d    = pair_t'(prev_y_reg) - pair_t'(up_data.vy);
        data_next.close_s   = pair_t'(prev_x_next) + pair_t'(first_x_next);
        data_next.close_d   = pair_t'(prev_y_next) - pair_t'(first_y_next);
        data_next.edge_en   = !is_first && !full_hit;
        data_next.box.min_x = min_x_next;
        data_next.box.min_y = min_y_next;
        data_next.box.max_x = max_x_next;
        data_next.box.max_y = max_y_next;
        data_next.box.total = seen_next;
        data_next.box.ovf   = ovf_next;
        data_next.box.last  = up_data.is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            min_x_reg   <= '0;
            min_y_reg   <= '0;
            max_x_reg   <= '0;
            max_y_reg   <= '0;
            seen_reg    <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (take)
        begin
            if (up_data.is_last)
            begin
                first_x_reg <= '0;
                first_y_reg <= '0;
                prev_x_reg  <= '0;
                prev_y_reg  <= '0;
                min_x_reg   <= '0;
                min_y_reg   <= '0;
                max_x_reg   <= '0;
                max_y_reg   <= '0;
                seen_reg    <= '0;
                ovf_reg     <= 1'b0;
            end
            else
            begin
                first_x_reg <= first_x_next;
                first_y_reg <= first_y_next;
                prev_x_reg  <= prev_x_next;
                prev_y_reg  <= prev_y_next;
                min_x_reg   <= min_x_next;
                min_y_reg   <= min_y_next;
                max_x_reg   <= max_x_next;
                max_y_reg   <= max_y_next;
                seen_reg    <= seen_next;
                ovf_reg     <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) seen_reg <= COUNT_MAX)
        else $error("Vertex count ran past its limit.");

    assert property (@(posedge clk) disable iff (!rst_n) ovf_reg |-> seen_reg == COUNT_MAX)
        else $error("Overflow flag set without a full vertex count.");
`endif

endmodule

FILE: rtl/pab_mac.sv
// ----------------------------------------------------------------------------
// Polygon shoelace multiply-accumulate
// Multiplies the edge and closing operands, then accumulates the edge terms
// and hands the partial sum and closing term of each polygon onward.
// ----------------------------------------------------------------------------
module pab_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_stall,
    input  pab_pkg::pab_track_t up_data,
    output logic                dn_valid,
    input  logic                dn_stall,
    output pab_pkg::pab_part_t  dn_data
);
    import pab_pkg::*;

    logic      v2_reg, v3_reg;
    pab_prod_t p2_reg, p2_next;
    pab_part_t p3_reg, p3_next;
    acc_t      acc_reg, acc_add;
    logic      s3_stall, take2, take3;

    assign s3_stall = v3_reg && dn_stall;
    assign up_stall = v2_reg && s3_stall;
    assign take2    = up_valid && !up_stall;
    assign take3    = v2_reg && !s3_stall;
    assign dn_valid = v3_reg;
    assign dn_data  = p3_reg;

    always_comb
    begin
        p2_next.edge_prod  = up_data.edge_en ?
                             term_t'(up_data.edge_s) * term_t'(up_data.edge_d) : '0;
        p2_next.close_prod = term_t'(up_data.close_s) * term_t'(up_data.close_d);
        p2_next.box        = up_data.box;

        acc_add            = acc_reg + acc_t'(p2_reg.edge_prod);
        p3_next.partial    = acc_add;
        p3_next.close_prod = p2_reg.close_prod;
        p3_next.box        = p2_reg.box;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            if (!up_stall)
            begin
                v2_reg <= up_valid;
            end
            if (!s3_stall)
            begin
                v3_reg <= v2_reg && p2_reg.box.last;
            end
            if (take3)
            begin
                acc_reg <= p2_reg.box.last ? '0 : acc_add;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            p2_reg <= p2_next;
        end
        if (take3 && p2_reg.box.last)
        begin
            p3_reg <= p3_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        take3 && p2_reg.box.last |=> acc_reg == '0)
        else $error("Accumulator not cleared after the closing vertex.");
`endif

endmodule

FILE: rtl/pab_final.sv
// ----------------------------------------------------------------------------
// Polygon area finish
// Adds the closing term, takes the magnitude, saturates it and holds the
// finished result in the output register.
// ----------------------------------------------------------------------------
module pab_final (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_stall,
    input  pab_pkg::pab_part_t up_data,
    output logic               dn_valid,
    input  logic               dn_stall,
    output pab_pkg::pab_out_t  dn_data
);
    import pab_pkg::*;

    logic     v4_reg, v5_reg;
    acc_t     sum_reg, sum_next, mag;
    pab_box_t box_reg;
    pab_out_t out_reg, out_next;
    logic     s5_stall;

    assign s5_stall = v5_reg && dn_stall;
    assign up_stall = v4_reg && s5_stall;
    assign dn_valid = v5_reg;
    assign dn_data  = out_reg;

    always_comb
    begin
        sum_next = up_data.partial + acc_t'(up_data.close_prod);
        mag      = sum_reg[ACC_W-1] ? acc_t'(-sum_reg) : sum_reg;
        if (box_reg.ovf || mag > AREA_CAP)
        begin
            mag = AREA_CAP;
        end
        out_next.twice_area   = mag[AREA_W-1:0];
        out_next.min_x        = box_reg.min_x;
        out_next.min_y        = box_reg.min_y;
        out_next.max_x        = box_reg.max_x;
        out_next.max_y        = box_reg.max_y;
        out_next.vertex_total = box_reg.total;
        out_next.too_many     = box_reg.ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (!up_stall)
            begin
                v4_reg <= up_valid;
            end
            if (!s5_stall)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
        begin
            sum_reg <= sum_next;
            box_reg <= up_data.box;
        end
        if (v4_reg && !s5_stall)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> acc_t'(out_reg.twice_area) <= AREA_CAP)
        else $error("Reported area exceeds the saturation limit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid && out_reg.too_many |-> acc_t'(out_reg.twice_area) == AREA_CAP)
        else $error("Too many vertices but the area is not saturated.");

    assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> out_reg.vertex_total != '0)
        else $error("Result reported with no vertices.");
`endif

endmodule

FILE: rtl/polygon_area_and_bounds.sv
// ----------------------------------------------------------------------------
// Polygon area and bounds
// Streaming shoelace area and bounding box of a polygon, one vertex per
// transaction, one result transaction per polygon.
// ----------------------------------------------------------------------------
// The block accepts one vertex per clock cycle while vertex_stall is low,
// and the vertex that carries is_last closes the polygon and yields one
// result: twice the polygon area as an exact unsigned value saturated at
// 2^42, the bounding box, the vertex count and a flag for polygons longer
// than the vertex limit. Vertices past the limit still widen the box but
// add no term to the area, which is then reported saturated. The work runs
// through six registers (input, vertex tracker, multipliers, accumulator,
// closing sum, output); the last vertex passes through them in that order
// before result_valid rises. The single accumulator update per vertex sets
// the rate of one vertex per cycle, and a stall on the result side fills
// the pipeline before it stalls the vertex side.
module polygon_area_and_bounds (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_stall,
    input  pab_pkg::pab_in_t  vertex,
    output logic              result_valid,
    input  logic              result_stall,
    output pab_pkg::pab_out_t result
);
    import pab_pkg::*;

    logic       in_valid_reg;
    pab_in_t    in_data_reg;
    logic       trk_stall;
    logic       trk_valid;
    pab_track_t trk_data;
    logic       mac_stall;
    logic       mac_valid;
    pab_part_t  mac_data;
    logic       fin_stall;

    assign vertex_stall = in_valid_reg && trk_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!vertex_stall)
        begin
            in_valid_reg <= vertex_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vertex_valid && !vertex_stall)
        begin
            in_data_reg <= vertex;
        end
    end

    pab_track u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid_reg),
        .up_stall (trk_stall),
        .up_data  (in_data_reg),
        .dn_valid (trk_valid),
        .dn_stall (mac_stall),
        .dn_data  (trk_data)
    );

    pab_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (trk_valid),
        .up_stall (mac_stall),
        .up_data  (trk_data),
        .dn_valid (mac_valid),
        .dn_stall (fin_stall),
        .dn_data  (mac_data)
    );

    pab_final u_final (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mac_valid),
        .up_stall (fin_stall),
        .up_data  (mac_data),
        .dn_valid (result_valid),
        .dn_stall (result_stall),
        .dn_data  (result)
    );

endmodule

FILE: test/polygon_area_and_bounds_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polygon area and bounds testbench
// Streams polygons into the block one vertex per transaction. A local model
// tracks the shoelace sum, bounding box and vertex count, and predicts one
// result per polygon. Each result transaction is checked field by field
// against the oldest prediction. The run covers corner polygons, both winding
// orders, the vertex limit, a long result stall and random traffic.
// ----------------------------------------------------------------------------
module polygon_area_and_bounds_test;

    import pab_pkg::*;

    localparam logic [63:0] AREA_LIMIT = 64'd1 << (AREA_W - 1);
    localparam coord_t      COORD_LO   = coord_t'(16'sh8000);
    localparam coord_t      COORD_HI   = coord_t'(16'sh7FFF);

    logic     clk;
    logic     rst_n        = 1'b0;
    logic     vertex_valid = 1'b0;
    logic     vertex_stall;
    pab_in_t  vertex       = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    pab_out_t result;

    int send_idle_pct    = 0;
    int result_stall_pct = 0;
    int hold_left        = 0;
    int bad_results      = 0;

    pab_out_t area_box_expect[$];

    coord_t            poly_first_x;
    coord_t            poly_first_y;
    coord_t            poly_prev_x;
    coord_t            poly_prev_y;
    coord_t            box_lo_x;
    coord_t            box_lo_y;
    coord_t            box_hi_x;
    coord_t            box_hi_y;
    logic signed [63:0] shoelace_sum = '0;
    int unsigned       vertices_seen = 0;
    logic              vertex_overflow = 1'b0;

    polygon_area_and_bounds u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic signed [63:0] edge_product(coord_t xa, coord_t ya,
                                                        coord_t xb, coord_t yb);
        logic signed [63:0] s;
        logic signed [63:0] d;
        s = longint'(xa) + longint'(xb);
        d = longint'(ya) - longint'(yb);
        return s * d;
    endfunction

    task automatic track_vertex(input pab_in_t v);
        coord_t             x;
        coord_t             y;
        logic signed [63:0] closed;
        logic        [63:0] mag;
        pab_out_t           res;
        x = v.vx;
        y = v.vy;
        if (vertices_seen == 0)
        begin
            poly_first_x = x;
            poly_first_y = y;
            poly_prev_x  = x;
            poly_prev_y  = y;
            box_lo_x     = x;
            box_hi_x     = x;
            box_lo_y     = y;
            box_hi_y     = y;
            shoelace_sum = '0;
            vertices_seen = 1;
        end
        else
        begin
            if (vertices_seen < MAX_VERTICES)
            begin
                shoelace_sum += edge_product(poly_prev_x, poly_prev_y, x, y);
                poly_prev_x  = x;
                poly_prev_y  = y;
                vertices_seen++;
            end
            else
            begin
                vertex_overflow = 1'b1;
            end
            if (x < box_lo_x) box_lo_x = x;
            if (x > box_hi_x) box_hi_x = x;
            if (y < box_lo_y) box_lo_y = y;
            if (y > box_hi_y) box_hi_y = y;
        end
        if (!v.is_last)
            return;
        if (vertex_overflow)
        begin
            mag = AREA_LIMIT;
        end
        else
        begin
            closed = shoelace_sum + edge_product(poly_prev_x, poly_prev_y,
                                                 poly_first_x, poly_first_y);
            mag = (closed < 0) ? 64'(-closed) : 64'(closed);
            if (mag > AREA_LIMIT)
                mag = AREA_LIMIT;
        end
        res.twice_area   = mag[AREA_W-1:0];
        res.min_x        = box_lo_x;
        res.min_y        = box_lo_y;
        res.max_x        = box_hi_x;
        res.max_y        = box_hi_y;
        res.vertex_total = count_t'(vertices_seen);
        res.too_many     = vertex_overflow;
        area_box_expect.push_back(res);
        poly_first_x = '0;
        poly_first_y = '0;
        poly_prev_x  = '0;
        poly_prev_y  = '0;
        box_lo_x     = '0;
        box_lo_y     = '0;
        box_hi_x     = '0;
        box_hi_y     = '0;
        shoelace_sum = '0;
        vertices_seen = 0;
        vertex_overflow = 1'b0;
    endtask

    // Called in the time step of a rising edge. Valid stays high after the
    // transaction so that back-to-back vertices need no second assignment.
    task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
        pab_in_t item;
        logic    taken;
        item.vx      = x;
        item.vy      = y;
        item.is_last = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            vertex_valid <= 1'b0;
            @(posedge clk);
        end
        vertex_valid <= 1'b1;
        vertex       <= item;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !vertex_stall;
            @(posedge clk);
        end
        track_vertex(item);
    endtask

    task automatic wait_for_results();
        vertex_valid <= 1'b0;
        while (area_box_expect.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_traffic(input int idle_pct, input int stall_pct, input int hold);
        vertex_valid <= 1'b0;
        @(negedge clk);
        send_idle_pct    = idle_pct;
        result_stall_pct = stall_pct;
        hold_left        = hold;
        @(posedge clk);
    endtask

    function automatic coord_t random_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return coord_t'($urandom);
        if (pick < 80)
            return coord_t'(int'($urandom_range(200)) - 100);
        case ($urandom_range(3))
            0: return COORD_LO;
            1: return COORD_HI;
            2: return coord_t'(0);
            default: return coord_t'(-1);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < result_stall_pct);
        end
    end

    // Inputs change only at rising edges, so a transaction seen here is the
    // one that completes at the next rising edge.
    always @(negedge clk)
    begin
        pab_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (area_box_expect.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result: area %0d total %0d",
                             result.twice_area, result.vertex_total);
            end
            else
            begin
                want = area_box_expect.pop_front();
                if (result.twice_area !== want.twice_area ||
                    result.min_x !== want.min_x || result.min_y !== want.min_y ||
                    result.max_x !== want.max_x || result.max_y !== want.max_y ||
                    result.vertex_total !== want.vertex_total ||
                    result.too_many !== want.too_many)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display({"mismatch: expected area %0d box (%0d,%0d)-(%0d,%0d) ",
                                  "total %0d over %0b, got area %0d box (%0d,%0d)-(%0d,%0d) ",
                                  "total %0d over %0b"},
                                 want.twice_area, want.min_x, want.min_y,
                                 want.max_x, want.max_y, want.vertex_total,
                                 want.too_many, result.twice_area, result.min_x,
                                 result.min_y, result.max_x, result.max_y,
                                 result.vertex_total, result.too_many);
                end
            end
        end
    end

    task automatic test_corner_polygons();
        send_vertex(COORD_LO, COORD_LO, 1'b1);
        send_vertex(COORD_HI, COORD_HI, 1'b1);
        send_vertex(COORD_LO, COORD_HI, 1'b0);
        send_vertex(COORD_HI, COORD_LO, 1'b1);
        send_vertex(COORD_HI, COORD_HI, 1'b0);
        send_vertex(COORD_HI, COORD_LO, 1'b0);
        send_vertex(COORD_LO, COORD_LO, 1'b0);
        send_vertex(COORD_LO, COORD_HI, 1'b1);
        send_vertex(coord_t'(5), coord_t'(5), 1'b0);
        send_vertex(coord_t'(5), coord_t'(5), 1'b0);
        send_vertex(coord_t'(5), coord_t'(5), 1'b1);
    endtask

    task automatic test_winding_order();
        send_vertex(coord_t'(0), coord_t'(0), 1'b0);
        send_vertex(coord_t'(4), coord_t'(0), 1'b0);
        send_vertex(coord_t'(0), coord_t'(3), 1'b1);
        send_vertex(coord_t'(0), coord_t'(0), 1'b0);
        send_vertex(coord_t'(0), coord_t'(3), 1'b0);
        send_vertex(coord_t'(4), coord_t'(0), 1'b1);
        send_vertex(COORD_LO, COORD_HI, 1'b0);
        send_vertex(COORD_LO, COORD_LO, 1'b0);
        send_vertex(COORD_HI, COORD_LO, 1'b0);
        send_vertex(COORD_HI, COORD_HI, 1'b1);
    endtask

    task automatic test_vertex_limit();
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            case (i % 4)
                0: send_vertex(COORD_HI, COORD_HI, 1'b0);
                1: send_vertex(COORD_HI, COORD_LO, 1'b0);
                2: send_vertex(COORD_LO, COORD_LO, 1'b0);
                default: send_vertex(COORD_LO, COORD_HI, i == MAX_VERTICES - 1);
            endcase
        end
        for (int i = 0; i < MAX_VERTICES; i++)
            send_vertex(coord_t'(int'($urandom_range(200)) - 100),
                        coord_t'(int'($urandom_range(200)) - 100), 1'b0);
        send_vertex(COORD_LO, COORD_HI, 1'b0);
        send_vertex(COORD_HI, COORD_LO, 1'b1);
    endtask

    task automatic test_output_backpressure();
        set_traffic(0, 0, 300);
        for (int p = 0; p < 40; p++)
            for (int i = 0; i < 3; i++)
                send_vertex(random_coord(), random_coord(), i == 2);
        wait_for_results();
    endtask

    task automatic test_random_polygons(input int idle_pct, input int stall_pct,
                                        input int vertex_budget);
        int sent;
        int sides;
        int pick;
        sent = 0;
        set_traffic(idle_pct, stall_pct, 0);
        while (sent < vertex_budget)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                sides = 1;
            else if (pick < 10)
                sides = 2;
            else if (pick < 90)
                sides = $urandom_range(8, 3);
            else
                sides = $urandom_range(40, 9);
            for (int i = 0; i < sides; i++)
                send_vertex(random_coord(), random_coord(), i == sides - 1);
            sent += sides;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_polygons();
        test_winding_order();
        test_vertex_limit();
        test_output_backpressure();
        test_random_polygons(0, 0, 200);
        test_random_polygons(64, 0, 200);
        test_random_polygons(0, 64, 200);
        test_random_polygons(7, 7, 200);
        wait_for_results();
        repeat (20) @(posedge clk);
        if (bad_results == 0 && area_box_expect.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
